// ===== rtl/core/tlgs_pkg.sv =====
// Shared types and constants for the toroidal stencil unit.
// No dependencies; imported by tlgs_wrap, tlgs_scale, the top module and the testbench.
`default_nettype none
package tlgs_pkg;

    // Default grid bounds
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Field widths
    localparam int COORD_W = 16;
    localparam int VAL_W   = 32;
    localparam int K_W     = 32;
    localparam int DIFF_W  = 35;
    localparam int RES_W   = 48;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_GRID_W   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GRID_H   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INV_DXSQ = 2'd2;
    localparam logic [IDX_W-1:0] CFG_INV_2DX  = 2'd3;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Scaler result bundle
    typedef struct packed {
        logic                    done;
        logic                    sat;
        logic signed [RES_W-1:0] value;
    } t_sc_res;

endpackage
`default_nettype wire

// ===== rtl/core/tlgs_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tlgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/tlgs_wrap.sv =====
// Iterative floored remainder of a signed 16-bit coordinate by a grid size.
// Depends on tlgs_pkg. One quotient bit per cycle.
`default_nettype none
module tlgs_wrap #(
    parameter int MW = 9
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [tlgs_pkg::COORD_W-1:0]    i_val,
    input  wire logic [MW-1:0]                   i_mod,
    output logic                                 o_done,
    output logic [MW-1:0]                        o_rem
);
    import tlgs_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_mag;
    logic [MW-1:0]      r_rem;
    logic [MW-1:0]      r_mod;
    logic               r_neg;
    logic [MW:0]        trial;
    logic [MW-1:0]      n_rem;

    // Restoring step: shift in next bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_mag[COORD_W-1]};
        if (trial >= {1'b0, r_mod}) begin
            n_rem = MW'(trial - {1'b0, r_mod});
        end else begin
            n_rem = MW'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_val[COORD_W-1];
                r_mag  <= i_val[COORD_W-1] ? (~i_val + 1'b1) : i_val;
                r_rem  <= '0;
                r_mod  <= i_mod;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_mag <= r_mag << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Negative operands fold back into [0, n)
    assign o_rem  = (r_neg && r_rem != '0) ? (r_mod - r_rem) : r_rem;
    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/core/tlgs_scale.sv =====
// Shared Q16.16 scaler: difference times factor, round, saturate to 48 bits.
// Depends on tlgs_pkg. Two 35x16 partial products, the low half in S_LO, then the high half in S_HI.
`default_nettype none
module tlgs_scale (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [tlgs_pkg::DIFF_W-1:0] i_diff,
    input  wire logic [tlgs_pkg::K_W-1:0]           i_k,
    output tlgs_pkg::t_sc_res                       o_res
);
    import tlgs_pkg::*;

    localparam int PW = DIFF_W + 16;
    localparam int QW = PW + 1;
    localparam logic [QW-1:0] POS_LIM = QW'(48'h7FFF_FFFF_FFFF);
    localparam logic [QW-1:0] NEG_LIM = QW'(48'h8000_0000_0000);
    localparam logic [QW-1:0] HALF    = QW'(16'h8000);

    typedef enum logic [1:0] {S_IDLE, S_LO, S_HI, S_FIN} t_state;

    t_state            r_state;
    logic              r_neg;
    logic [DIFF_W-1:0] r_mag;
    logic [K_W-1:0]    r_k;
    logic [PW-1:0]     r_lo;
    logic [PW-1:0]     r_hi;
    logic [QW-1:0]     q;
    logic [QW-1:0]     q_clip;
    logic              sat;

    // Shared multiplier operand select
    logic [15:0]   mul_k;
    logic [PW-1:0] mul_p;
    assign mul_k = (r_state == S_LO) ? r_k[15:0] : r_k[31:16];
    assign mul_p = PW'(r_mag) * PW'(mul_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_diff[DIFF_W-1];
                        r_mag   <= i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
                        r_k     <= i_k;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_lo    <= mul_p;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hi    <= mul_p;
                    r_state <= S_FIN;
                end
                S_FIN:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Round half away from zero on the magnitude, then clip
    always_comb begin
        q = QW'(r_hi) + ((QW'(r_lo) + HALF) >> 16);
        if (r_neg) begin
            sat    = q > NEG_LIM;
            q_clip = sat ? NEG_LIM : q;
        end else begin
            sat    = q > POS_LIM;
            q_clip = sat ? POS_LIM : q;
        end
    end

    assign o_res.done  = (r_state == S_FIN);
    assign o_res.sat   = sat;
    assign o_res.value = r_neg ? RES_W'(-q_clip) : RES_W'(q_clip);
endmodule
`default_nettype wire

// ===== rtl/core/toroidal_laplacian_gradient_stencil_unit.sv =====
// Toroidal five-point Laplacian / central-difference gradient unit.
// Handles one item at a time: a new transfer is taken only in idle, once the last write is done
// or the last result is loaded. A query runs two remainder passes on the shared divider, five
// reads of the single RAM port, three scaler passes and one output load.
// Reset (sync, active low) restores the size and factor registers; the field
// store is not cleared and a cell reads as garbage until written.
`default_nettype none
module toroidal_laplacian_gradient_stencil_unit #(
    parameter int MAX_WIDTH  = tlgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tlgs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config write port
    input  wire logic                        i_cfg_we,
    input  wire logic [tlgs_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tlgs_pkg::K_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [63:0]                 s_axis_tdata,  // coord_x, coord_y, write_value
    input  wire logic                        s_axis_tuser,  // opcode
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [143:0]                     m_axis_tdata,  // laplacian, grad_x, grad_y
    output logic                             m_axis_tuser   // saturated
);
    import tlgs_pkg::*;

    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SW   = $clog2(MAXD + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int DEP  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(DEP);

    typedef enum logic [3:0] {
        S_IDLE, S_WX, S_WY, S_ADR, S_RD, S_CAP, S_WR, S_SC, S_OUT
    } t_state;

    // Config registers
    logic [CFG_W-1:0] r_grid_w, r_grid_h;
    logic [K_W-1:0]   r_inv_dxsq, r_inv_2dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w   <= CFG_W'(256);
            r_grid_h   <= CFG_W'(256);
            r_inv_dxsq <= K_W'(65536);
            r_inv_2dx  <= K_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_W:   r_grid_w   <= i_cfg_data[CFG_W-1:0];
                CFG_GRID_H:   r_grid_h   <= i_cfg_data[CFG_W-1:0];
                CFG_INV_DXSQ: r_inv_dxsq <= i_cfg_data;
                CFG_INV_2DX:  r_inv_2dx  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes in use: zero acts as one, clamp to the maximum
    logic [SW-1:0] w_use, h_use;
    always_comb begin
        if (r_grid_w == '0)                       w_use = SW'(1);
        else if (32'(r_grid_w) > 32'(MAX_WIDTH))  w_use = SW'(MAX_WIDTH);
        else                                      w_use = SW'(r_grid_w);
        if (r_grid_h == '0)                       h_use = SW'(1);
        else if (32'(r_grid_h) > 32'(MAX_HEIGHT)) h_use = SW'(MAX_HEIGHT);
        else                                      h_use = SW'(r_grid_h);
    end

    t_state                  r_state;
    logic                    r_op;
    logic [COORD_W-1:0]      r_raw_y;
    logic [VAL_W-1:0]        r_wval;
    logic [XW-1:0]           r_cx;
    logic [YW-1:0]           r_cy;
    logic [2:0]              r_cell;
    logic [AW-1:0]           r_addr;
    logic signed [VAL_W-1:0] r_c, r_l, r_r, r_u, r_d;
    logic [1:0]              r_sel;
    logic                    r_sc_go;
    logic signed [RES_W-1:0] r_lap, r_gx, r_gy;
    logic                    r_sat;
    logic                    r_m_valid;

    logic s_accept;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Shared remainder unit
    logic          wr_start, wr_done;
    logic [SW-1:0] wr_rem;
    assign wr_start = (r_state == S_IDLE && s_accept) || (r_state == S_WX && wr_done);

    tlgs_wrap #(.MW(SW)) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wr_start),
        .i_val   ((r_state == S_IDLE) ? s_axis_tdata[15:0] : r_raw_y),
        .i_mod   ((r_state == S_IDLE) ? w_use : h_use),
        .o_done  (wr_done),
        .o_rem   (wr_rem)
    );

    // Neighbor coordinates and cell address
    logic [XW-1:0]      xm, xp, xsel;
    logic [YW-1:0]      ym, yp, ysel;
    logic [YW+SW-1:0]   prod;
    logic [AW-1:0]      addr_calc;
    always_comb begin
        xm = (r_cx == '0) ? XW'(w_use - 1'b1) : XW'(r_cx - 1'b1);
        xp = ((32'(r_cx) + 1) == 32'(w_use)) ? '0 : XW'(r_cx + 1'b1);
        ym = (r_cy == '0) ? YW'(h_use - 1'b1) : YW'(r_cy - 1'b1);
        yp = ((32'(r_cy) + 1) == 32'(h_use)) ? '0 : YW'(r_cy + 1'b1);
        case (r_cell)
            3'd1:    begin xsel = xm;   ysel = r_cy; end
            3'd2:    begin xsel = xp;   ysel = r_cy; end
            3'd3:    begin xsel = r_cx; ysel = ym;   end
            3'd4:    begin xsel = r_cx; ysel = yp;   end
            default: begin xsel = r_cx; ysel = r_cy; end
        endcase
        prod      = (YW+SW)'(ysel) * (YW+SW)'(w_use);
        addr_calc = AW'(prod) + AW'(xsel);
    end

    // Field store
    logic [VAL_W-1:0] ram_q;
    tlgs_ram #(.WIDTH(VAL_W), .DEPTH(DEP)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_re    (r_state == S_RD),
        .i_addr  (r_addr),
        .i_wdata (r_wval),
        .o_rdata (ram_q)
    );

    // Stencil differences
    logic signed [DIFF_W-1:0] d_lap, d_gx, d_gy, sc_diff;
    logic [K_W-1:0]           sc_k;
    always_comb begin
        d_lap = DIFF_W'(r_l) + DIFF_W'(r_r) + DIFF_W'(r_u) + DIFF_W'(r_d)
              - (DIFF_W'(r_c) <<< 2);
        d_gx  = DIFF_W'(r_r) - DIFF_W'(r_l);
        d_gy  = DIFF_W'(r_d) - DIFF_W'(r_u);
        case (r_sel)
            2'd0:    begin sc_diff = d_lap; sc_k = r_inv_dxsq; end
            2'd1:    begin sc_diff = d_gx;  sc_k = r_inv_2dx;  end
            default: begin sc_diff = d_gy;  sc_k = r_inv_2dx;  end
        endcase
    end

    t_sc_res sc_res;
    tlgs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sc_go),
        .i_diff  (sc_diff),
        .i_k     (sc_k),
        .o_res   (sc_res)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sc_go   <= 1'b0;
            r_m_valid <= 1'b0;
            r_cell    <= '0;
            r_sel     <= '0;
        end else begin
            r_sc_go <= 1'b0;
            if (m_axis_tready) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_op    <= s_axis_tuser;
                        r_raw_y <= s_axis_tdata[31:16];
                        r_wval  <= s_axis_tdata[63:32];
                        r_state <= S_WX;
                    end
                end
                S_WX: begin
                    if (wr_done) begin
                        r_cx    <= XW'(wr_rem);
                        r_state <= S_WY;
                    end
                end
                S_WY: begin
                    if (wr_done) begin
                        r_cy    <= YW'(wr_rem);
                        r_cell  <= '0;
                        r_state <= S_ADR;
                    end
                end
                S_ADR: begin
                    r_addr  <= addr_calc;
                    r_state <= (r_op == OP_WRITE) ? S_WR : S_RD;
                end
                S_WR:  r_state <= S_IDLE;
                S_RD:  r_state <= S_CAP;
                S_CAP: begin
                    case (r_cell)
                        3'd0:    r_c <= ram_q;
                        3'd1:    r_l <= ram_q;
                        3'd2:    r_r <= ram_q;
                        3'd3:    r_u <= ram_q;
                        default: r_d <= ram_q;
                    endcase
                    if (r_cell == 3'd4) begin
                        r_sel   <= '0;
                        r_sat   <= 1'b0;
                        r_sc_go <= 1'b1;
                        r_state <= S_SC;
                    end else begin
                        r_cell  <= r_cell + 1'b1;
                        r_state <= S_ADR;
                    end
                end
                S_SC: begin
                    if (sc_res.done) begin
                        r_sat <= r_sat | sc_res.sat;
                        case (r_sel)
                            2'd0:    r_lap <= sc_res.value;
                            2'd1:    r_gx  <= sc_res.value;
                            default: r_gy  <= sc_res.value;
                        endcase
                        if (r_sel == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_sc_go <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    // output register frees up when the previous transfer goes
                    if (!r_m_valid || m_axis_tready) begin
                        m_axis_tdata <= {r_gy, r_gx, r_lap};
                        m_axis_tuser <= r_sat;
                        r_m_valid    <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
endmodule
`default_nettype wire

// ===== tb/tb_toroidal_laplacian_gradient_stencil_unit.sv =====
// Self-checking testbench for the toroidal stencil unit: directed table, then random traffic.
// Depends on tlgs_pkg and toroidal_laplacian_gradient_stencil_unit, which brings in its submodules.
`timescale 1ns / 100ps
module tb_toroidal_laplacian_gradient_stencil_unit;
    import tlgs_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 100;
    localparam int  LONG_HOLD   = 400;
    localparam int  GRID_MAX_W  = MAX_WIDTH_DEF;
    localparam int  GRID_MAX_H  = MAX_HEIGHT_DEF;
    localparam int  STORE_DEPTH = GRID_MAX_W * GRID_MAX_H;

    typedef struct {
        logic [RES_W-1:0] lap;
        logic [RES_W-1:0] gx;
        logic [RES_W-1:0] gy;
        logic             sat;
    } t_stencil_res;

    typedef struct {
        logic               op;
        int                 x;
        int                 y;
        logic [VAL_W-1:0]   val;
        bit                 typed;
        t_stencil_res       res;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [K_W-1:0]     i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata = '0;   // coord_x, coord_y, write_value
    logic               s_axis_tuser = 1'b0; // opcode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [143:0]       m_axis_tdata;        // laplacian, grad_x, grad_y
    logic               m_axis_tuser;        // saturated

    toroidal_laplacian_gradient_stencil_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Mirror of the block's registers and field store
    logic [CFG_W-1:0]   grid_w_reg;
    logic [CFG_W-1:0]   grid_h_reg;
    logic [K_W-1:0]     inv_dxsq_reg;
    logic [K_W-1:0]     inv_2dx_reg;
    logic [VAL_W-1:0]   field_mem [STORE_DEPTH];
    bit                 field_seen [STORE_DEPTH];

    t_stencil_res       pending_res [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 gap_max = 0;
    int                 stall_max = 0;
    int                 stall_cnt = 0;
    bit                 took = 1'b0;
    bit                 long_hold_req = 1'b0;
    bit                 long_hold_on = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[toroidal_laplacian_gradient_stencil_unit] ERROR");
            $finish;
        end
    end

    function automatic int size_used(input logic [CFG_W-1:0] r, input int maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return int'(r);
    endfunction

    function automatic int wrap(input int c, input int n);
        return ((c % n) + n) % n;
    endfunction

    function automatic int cell_addr(input int x, input int y);
        int w;
        int h;
        w = size_used(grid_w_reg, GRID_MAX_W);
        h = size_used(grid_h_reg, GRID_MAX_H);
        return wrap(y, h) * w + wrap(x, w);
    endfunction

    function automatic longint cell_val(input int x, input int y);
        return longint'($signed(field_mem[cell_addr(x, y)]));
    endfunction

    // Exact product by unsigned Q16.16 factor, round half away from zero, clip to 48 bits
    function automatic logic [RES_W-1:0] scale_clip(input longint d, input logic [K_W-1:0] k,
                                                     inout logic sat);
        logic [95:0] mag;
        logic [95:0] q;
        mag = (d < 0) ? 96'(-d) : 96'(d);
        q = (mag * {64'd0, k} + 96'h8000) >> 16;
        if (d < 0) begin
            if (q > 96'h8000_0000_0000) begin
                q = 96'h8000_0000_0000;
                sat = 1'b1;
            end
            return RES_W'(-q);
        end
        if (q > 96'h7FFF_FFFF_FFFF) begin
            q = 96'h7FFF_FFFF_FFFF;
            sat = 1'b1;
        end
        return q[RES_W-1:0];
    endfunction

    function automatic t_stencil_res stencil_at(input int x, input int y);
        t_stencil_res r;
        longint c, l, rt, u, dn;
        c  = cell_val(x, y);
        l  = cell_val(x - 1, y);
        rt = cell_val(x + 1, y);
        u  = cell_val(x, y - 1);
        dn = cell_val(x, y + 1);
        r.sat = 1'b0;
        r.lap = scale_clip(l + rt + u + dn - 4 * c, inv_dxsq_reg, r.sat);
        r.gx  = scale_clip(rt - l, inv_2dx_reg, r.sat);
        r.gy  = scale_clip(dn - u, inv_2dx_reg, r.sat);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                   input logic [RES_W-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Register write, only while the block is idle
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [K_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_GRID_W:   grid_w_reg = data[CFG_W-1:0];
            CFG_GRID_H:   grid_h_reg = data[CFG_W-1:0];
            CFG_INV_DXSQ: inv_dxsq_reg = data;
            CFG_INV_2DX:  inv_2dx_reg = data;
            default: ;
        endcase
    endtask

    // One input transfer; expectations are recorded at acceptance
    task automatic send_item(input logic op, input int x, input int y, input logic [VAL_W-1:0] v,
                             input bit typed, input t_stencil_res tres);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {v, 16'(y), 16'(x)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_WRITE) begin
            field_mem[cell_addr(x, y)] = v;
            field_seen[cell_addr(x, y)] = 1'b1;
        end else begin
            pending_res.push_back(typed ? tres : stencil_at(x, y));
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic put_cell(input int x, input int y, input logic [VAL_W-1:0] v);
        t_stencil_res none;
        none = '{default: '0};
        send_item(OP_WRITE, x, y, v, 1'b0, none);
    endtask

    // Query with every stencil cell written beforehand where needed
    task automatic query_cell(input int x, input int y);
        t_stencil_res none;
        int w;
        int h;
        int dx [5];
        int dy [5];
        none = '{default: '0};
        w = size_used(grid_w_reg, GRID_MAX_W);
        h = size_used(grid_h_reg, GRID_MAX_H);
        dx = '{0, -1, 1, 0, 0};
        dy = '{0, 0, 0, -1, 1};
        for (int i = 0; i < 5; i++)
            if (!field_seen[cell_addr(x + dx[i], y + dy[i])])
                put_cell(wrap(x + dx[i], w), wrap(y + dy[i], h), $urandom);
        send_item(OP_QUERY, x, y, $urandom, 1'b0, none);
    endtask

    task automatic wait_idle();
        wait (pending_res.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic random_traffic(input int n);
        int w;
        int h;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            end
            w = size_used(grid_w_reg, GRID_MAX_W);
            h = size_used(grid_h_reg, GRID_MAX_H);
            case ($urandom_range(0, 9))
                0, 1: put_cell($signed(16'($urandom)), $signed(16'($urandom)), $urandom);
                2:    query_cell($urandom_range(0, w - 1), $urandom_range(0, h - 1));
                default: query_cell($signed(16'($urandom)), $signed(16'($urandom)));
            endcase
        end
    endtask

    // Long receiver hold-off, counted here once requested
    initial begin
        wait (long_hold_req);
        @(negedge i_clk);
        long_hold_on <= 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        long_hold_on <= 1'b0;
    end

    // Result side: a random wait drawn after each transfer, plus the long hold-off
    always @(negedge i_clk) begin
        if (took) stall_cnt = $urandom_range(0, stall_max);
        if (long_hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            m_axis_tready <= 1'b0;
            stall_cnt = stall_cnt - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_stencil_res want;
        took <= m_axis_tvalid && m_axis_tready;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[47:0], '0);
            end else begin
                want = pending_res.pop_front();
                if (m_axis_tdata[47:0] !== want.lap)
                    report_mismatch("laplacian", m_axis_tdata[47:0], want.lap);
                if (m_axis_tdata[95:48] !== want.gx)
                    report_mismatch("grad_x", m_axis_tdata[95:48], want.gx);
                if (m_axis_tdata[143:96] !== want.gy)
                    report_mismatch("grad_y", m_axis_tdata[143:96], want.gy);
                if (m_axis_tuser !== want.sat)
                    report_mismatch("saturated", 48'(m_axis_tuser), 48'(want.sat));
            end
        end
    end

    t_stim_row dir_rows [13];

    initial begin
        t_stencil_res none;
        none = '{default: '0};
        grid_w_reg = 9'd256;
        grid_h_reg = 9'd256;
        inv_dxsq_reg = 32'd65536;
        inv_2dx_reg = 32'd32768;
        foreach (field_seen[i]) field_seen[i] = 1'b0;

        // Directed rows: small stencil at origin, then extremes at the coordinate corners
        dir_rows[0]  = '{OP_WRITE, 0, 0, 32'h0001_0000, 1'b0, none};
        dir_rows[1]  = '{OP_WRITE, -1, 0, 32'h0000_0000, 1'b0, none};
        dir_rows[2]  = '{OP_WRITE, 1, 0, 32'h0002_0000, 1'b0, none};
        dir_rows[3]  = '{OP_WRITE, 0, -1, 32'h0000_0000, 1'b0, none};
        dir_rows[4]  = '{OP_WRITE, 0, 1, 32'h0004_0000, 1'b0, none};
        dir_rows[5]  = '{OP_QUERY, 0, 0, 32'h0, 1'b1,
                         '{48'h2_0000, 48'h1_0000, 48'h2_0000, 1'b0}};
        dir_rows[6]  = '{OP_QUERY, -256, 256, 32'hFFFF_FFFF, 1'b0, none};
        dir_rows[7]  = '{OP_WRITE, 32767, -32768, 32'h8000_0000, 1'b0, none};
        dir_rows[8]  = '{OP_WRITE, 32766, -32768, 32'h7FFF_FFFF, 1'b0, none};
        dir_rows[9]  = '{OP_WRITE, 0, 0, 32'h7FFF_FFFF, 1'b0, none};
        dir_rows[10] = '{OP_WRITE, 32767, -1, 32'h7FFF_FFFF, 1'b0, none};
        dir_rows[11] = '{OP_WRITE, 32767, 1, 32'h7FFF_FFFF, 1'b0, none};
        dir_rows[12] = '{OP_QUERY, 32767, -32768, 32'h0, 1'b1,
                         '{48'h3_FFFF_FFFC, 48'h0, 48'h0, 1'b0}};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].res);

        // Long receiver hold-off while items keep coming
        long_hold_req = 1'b1;
        random_traffic(16);
        wait_idle();

        // Small grid, unity Laplacian scale, random gradient factor
        cfg_write(CFG_GRID_W, 32'd5);
        cfg_write(CFG_GRID_H, 32'd3);
        cfg_write(CFG_INV_DXSQ, 32'h0001_0000);
        cfg_write(CFG_INV_2DX, $urandom);
        random_traffic(90);
        // Sender pauses until everything has drained
        wait (pending_res.size() == 0);
        @(negedge i_clk);
        random_traffic(20);
        wait_idle();

        // Zero width acts as one column; largest factors force saturation
        cfg_write(CFG_GRID_W, 32'd0);
        cfg_write(CFG_GRID_H, 32'd3);
        cfg_write(CFG_INV_DXSQ, 32'hFFFF_FFFF);
        cfg_write(CFG_INV_2DX, 32'hFFFF_FFFF);
        random_traffic(50);
        wait_idle();

        // Zero height acts as one row
        cfg_write(CFG_GRID_W, 32'd4);
        cfg_write(CFG_GRID_H, 32'd0);
        random_traffic(50);
        wait_idle();

        // Oversize clips to the maximum; zero factors
        cfg_write(CFG_GRID_W, 32'd511);
        cfg_write(CFG_GRID_H, 32'd511);
        cfg_write(CFG_INV_DXSQ, 32'd0);
        cfg_write(CFG_INV_2DX, 32'd0);
        random_traffic(16);
        wait_idle();

        // Random small sizes and factors
        cfg_write(CFG_GRID_W, $urandom_range(1, 20));
        cfg_write(CFG_GRID_H, $urandom_range(1, 20));
        cfg_write(CFG_INV_DXSQ, $urandom);
        cfg_write(CFG_INV_2DX, $urandom);
        random_traffic(60);
        wait_idle();

        // Full width, single row
        cfg_write(CFG_GRID_W, 32'd256);
        cfg_write(CFG_GRID_H, 32'd1);
        cfg_write(CFG_INV_DXSQ, $urandom_range(0, 32'h0004_0000));
        random_traffic(40);

        wait (pending_res.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("[toroidal_laplacian_gradient_stencil_unit] OK");
        else
            $display("[toroidal_laplacian_gradient_stencil_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tlgs_pkg.sv
rtl/core/tlgs_ram.sv
rtl/core/tlgs_wrap.sv
rtl/core/tlgs_scale.sv
rtl/core/toroidal_laplacian_gradient_stencil_unit.sv
tb/tb_toroidal_laplacian_gradient_stencil_unit.sv
